// File: rtl/affine_image_warp_interp_top_defines.svh
// Assertion macros used by the warp top module.
`ifndef AFFINE_IMAGE_WARP_INTERP_TOP_DEFINES_SVH
`define AFFINE_IMAGE_WARP_INTERP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AIWI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AIWI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIWI_ASSERT(lbl, prop, msg)
`define AIWI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/aiwi_pkg.sv
package aiwi_pkg;

  localparam int IMG_W = 512;
  localparam int IMG_H = 512;

  localparam int Q_FRAC = 16;
  localparam int Q_ONE  = 65536;
  localparam int Q_HALF = 32768;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_PER_COL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_PER_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PER_COL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PER_ROW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd6;

  localparam logic MODE_BILINEAR = 1'b0;
  localparam logic MODE_NEAREST  = 1'b1;
  localparam logic OP_LOAD       = 1'b0;
  localparam logic OP_SAMPLE     = 1'b1;

  // Coefficient times a 10-bit signed coordinate, then a sum of three terms plus a half.
  localparam int PROD_W = CFG_W + 10;
  localparam int SUM_W  = PROD_W + 3;
  localparam int CRD_W  = SUM_W - Q_FRAC;

  // Four banks split by column and row parity; each bank holds a quarter image.
  localparam int XHW = ($clog2(IMG_W) > 1) ? $clog2(IMG_W) - 1 : 1;
  localparam int YHW = ($clog2(IMG_H) > 1) ? $clog2(IMG_H) - 1 : 1;
  localparam int A_W = XHW + YHW;
  localparam int BANK_DEPTH = 2 ** A_W;

  typedef logic [A_W-1:0] addr_t;
  typedef logic [7:0]     pixel_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       wbank;
    addr_t            waddr;
    pixel_t           wdata;
    logic [3:0][A_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic        valid;
    logic        in_range;
    logic        mode;
    logic        xs;
    logic        ys;
    logic [15:0] fx;
    logic [15:0] fy;
  } ctrl_t;

  // floor((a*65536 + f*(b-a)) / 65536); the result always lies between a and b.
  function automatic pixel_t lerp(input pixel_t a, input pixel_t b, input logic [15:0] f);
    logic signed [8:0]  d;
    logic signed [25:0] t;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    t = signed'({2'b00, a, 16'h0000}) + signed'({1'b0, f}) * d;
    return t[23:16];
  endfunction

endpackage

// File: rtl/affine_image_warp_interp_top.sv
// Affine image warp with bilinear or nearest-neighbor sampling.
// The input channel (in_valid/in_stall) carries load and sample transactions.
// A load writes pixel_in at (col, row) of the source image; it gives no result.
// A sample maps (col, row) through the six coefficients and returns one
// transaction on the output channel (out_valid/out_stall).
// The user must see that the configuration port (cfg_we, cfg_index, cfg_data)
// is written only while idle; the block itself does not enforce this. The
// block is a five-stage pipeline around four image banks split by column and
// row parity, so the four neighbors are read in the same cycle. One
// transaction is accepted per cycle unless in_stall is raised.
// Loads and samples reach the banks in acceptance order in the same stage.
// Reset clears the pipeline and sets the identity transform and bilinear mode.
// The image is undefined until loaded.
// While a result waits under out_stall, the whole pipeline holds and in_stall
// is raised; it drops in the same cycle as out_stall, so the waiting result and
// a new input transaction are accepted at the same edge.
`include "affine_image_warp_interp_top_defines.svh"

module affine_image_warp_interp_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [8:0]                     col,
  input  logic [8:0]                     row,
  input  logic [7:0]                     pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     pixel_out,
  output logic                           inside_res,
  input  logic                           cfg_we,
  input  logic [aiwi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aiwi_pkg::CFG_W-1:0]     cfg_data
);

  logic en;
  aiwi_pkg::mem_req_t req;
  aiwi_pkg::ctrl_t    ctrl;
  logic [3:0][7:0]    rdata;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  aiwi_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .op        (op),
    .col       (col),
    .row       (row),
    .pixel_in  (pixel_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .ctrl      (ctrl)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aiwi_ram #(
      .WIDTH (8),
      .DEPTH (aiwi_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (req.we && (req.wbank == 2'(b))),
      .waddr (req.waddr),
      .wdata (req.wdata),
      .re    (en),
      .raddr (req.raddr[b]),
      .rdata (rdata[b])
    );
  end

  aiwi_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctrl       (ctrl),
    .rdata      (rdata),
    .out_valid  (out_valid),
    .pixel_out  (pixel_out),
    .inside_res (inside_res)
  );

  `AIWI_ASSERT(a_outside_zero, out_valid && !inside_res |-> pixel_out == 8'd0, "outside result not zero")
  `AIWI_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !ctrl.valid, "pipeline not empty after reset")
  `AIWI_ASSERT(a_hold_ctrl, !en |=> $stable(ctrl), "pipeline moved while stalled")
  `AIWI_ASSERT(a_no_write_stalled, !en |-> !req.we, "bank written while stalled")

endmodule

// File: rtl/aiwi_ram.sv
module aiwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/aiwi_map.sv
module aiwi_map (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic                           op,
  input  logic [8:0]                     col,
  input  logic [8:0]                     row,
  input  logic [7:0]                     pixel_in,
  input  logic                           cfg_we,
  input  logic [aiwi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aiwi_pkg::CFG_W-1:0]     cfg_data,
  output aiwi_pkg::mem_req_t             req,
  output aiwi_pkg::ctrl_t                ctrl
);

  logic signed [aiwi_pkg::CFG_W-1:0] x_offset, x_per_col, x_per_row;
  logic signed [aiwi_pkg::CFG_W-1:0] y_offset, y_per_col, y_per_row;
  logic interp_mode;

  logic v1, op1, mode1;
  logic [8:0] col1, row1;
  logic [7:0] pix1;
  logic signed [aiwi_pkg::PROD_W-1:0] pxc, pxr, pyc, pyr;

  logic v2, op2, mode2;
  logic [8:0] col2, row2;
  logic [7:0] pix2;
  logic signed [aiwi_pkg::SUM_W-1:0] sx, sy;

  logic signed [aiwi_pkg::SUM_W-1:0] half;
  logic signed [aiwi_pkg::CRD_W-1:0] x1, y1, xlim, ylim;
  logic [aiwi_pkg::CRD_W-1:0] colx, rowx;
  logic in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset    <= '0;
      x_per_col   <= 32'sd65536;
      x_per_row   <= '0;
      y_offset    <= '0;
      y_per_col   <= '0;
      y_per_row   <= 32'sd65536;
      interp_mode <= aiwi_pkg::MODE_BILINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        aiwi_pkg::REG_X_OFFSET:    x_offset    <= cfg_data;
        aiwi_pkg::REG_X_PER_COL:   x_per_col   <= cfg_data;
        aiwi_pkg::REG_X_PER_ROW:   x_per_row   <= cfg_data;
        aiwi_pkg::REG_Y_OFFSET:    y_offset    <= cfg_data;
        aiwi_pkg::REG_Y_PER_COL:   y_per_col   <= cfg_data;
        aiwi_pkg::REG_Y_PER_ROW:   y_per_row   <= cfg_data;
        aiwi_pkg::REG_INTERP_MODE: interp_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: the four coefficient products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= op;
      col1  <= col;
      row1  <= row;
      pix1  <= pixel_in;
      mode1 <= interp_mode;
      pxc   <= x_per_col * signed'({1'b0, col});
      pxr   <= x_per_row * signed'({1'b0, row});
      pyc   <= y_per_col * signed'({1'b0, col});
      pyr   <= y_per_row * signed'({1'b0, row});
    end
  end

  // Stage 2: source point in Q.16; nearest mode adds a half so a floor rounds.
  assign half = (mode1 == aiwi_pkg::MODE_NEAREST) ?
                aiwi_pkg::SUM_W'(aiwi_pkg::Q_HALF) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      col2  <= col1;
      row2  <= row1;
      pix2  <= pix1;
      mode2 <= mode1;
      sx <= aiwi_pkg::SUM_W'(x_offset) + aiwi_pkg::SUM_W'(pxc) +
            aiwi_pkg::SUM_W'(pxr) + half;
      sy <= aiwi_pkg::SUM_W'(y_offset) + aiwi_pkg::SUM_W'(pyc) +
            aiwi_pkg::SUM_W'(pyr) + half;
    end
  end

  // Stage 3: bounds check and bank addressing; the arithmetic shift is a floor.
  assign x1 = sx[aiwi_pkg::SUM_W-1:aiwi_pkg::Q_FRAC];
  assign y1 = sy[aiwi_pkg::SUM_W-1:aiwi_pkg::Q_FRAC];
  assign xlim = (mode2 == aiwi_pkg::MODE_NEAREST) ?
                aiwi_pkg::CRD_W'(aiwi_pkg::IMG_W - 1) : aiwi_pkg::CRD_W'(aiwi_pkg::IMG_W - 2);
  assign ylim = (mode2 == aiwi_pkg::MODE_NEAREST) ?
                aiwi_pkg::CRD_W'(aiwi_pkg::IMG_H - 1) : aiwi_pkg::CRD_W'(aiwi_pkg::IMG_H - 2);
  assign in_range = !x1[aiwi_pkg::CRD_W-1] && (x1 < xlim) &&
                    !y1[aiwi_pkg::CRD_W-1] && (y1 < ylim);
  assign colx = aiwi_pkg::CRD_W'(col2);
  assign rowx = aiwi_pkg::CRD_W'(row2);

  always_comb begin
    req.we    = en && v2 && (op2 == aiwi_pkg::OP_LOAD) &&
                (colx < aiwi_pkg::CRD_W'(aiwi_pkg::IMG_W)) &&
                (rowx < aiwi_pkg::CRD_W'(aiwi_pkg::IMG_H));
    req.wbank = {row2[0], col2[0]};
    req.waddr = {rowx[aiwi_pkg::YHW:1], colx[aiwi_pkg::XHW:1]};
    req.wdata = pix2;
    // A bank whose parity differs from the base point holds the next column or row.
    for (int b = 0; b < 4; b++) begin
      req.raddr[b] = {y1[aiwi_pkg::YHW:1] + aiwi_pkg::YHW'(y1[0] & ~b[1]),
                      x1[aiwi_pkg::XHW:1] + aiwi_pkg::XHW'(x1[0] & ~b[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= v2 && (op2 == aiwi_pkg::OP_SAMPLE);
    end
    if (en) begin
      ctrl.in_range <= in_range;
      ctrl.mode     <= mode2;
      ctrl.xs       <= x1[0];
      ctrl.ys       <= y1[0];
      ctrl.fx       <= sx[15:0];
      ctrl.fy       <= sy[15:0];
    end
  end

endmodule

// File: rtl/aiwi_blend.sv
module aiwi_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  aiwi_pkg::ctrl_t ctrl,
  input  logic [3:0][7:0] rdata,
  output logic            out_valid,
  output logic [7:0]      pixel_out,
  output logic            inside_res
);

  logic [7:0] v11, v21, v12, v22;
  logic v4, inside4, mode4;
  logic [15:0] fy4;
  logic [7:0] r0, r1, near4;

  assign v11 = rdata[{ctrl.ys, ctrl.xs}];
  assign v21 = rdata[{ctrl.ys, ~ctrl.xs}];
  assign v12 = rdata[{~ctrl.ys, ctrl.xs}];
  assign v22 = rdata[{~ctrl.ys, ~ctrl.xs}];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside4 <= ctrl.in_range;
      mode4   <= ctrl.mode;
      fy4     <= ctrl.fy;
      near4   <= v11;
      r0      <= aiwi_pkg::lerp(v11, v21, ctrl.fx);
      r1      <= aiwi_pkg::lerp(v12, v22, ctrl.fx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_res <= inside4;
      if (!inside4) begin
        pixel_out <= '0;
      end else if (mode4 == aiwi_pkg::MODE_NEAREST) begin
        pixel_out <= near4;
      end else begin
        pixel_out <= aiwi_pkg::lerp(r0, r1, fy4);
      end
    end
  end

endmodule
